// ===== rtl/bsst_pkg.sv =====
// ----------------------------------------------------------------------------
// bsst_pkg
// Shared types and constants for the bounded sorted set table.
// ----------------------------------------------------------------------------
package bsst_pkg;

  localparam int DEPTH = 16;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam int OP_W  = 2;
  localparam int VAL_W = 32;
  localparam int POS_W = 5;
  localparam int CAP_W = 5;
  localparam int ST_W  = 3;
  localparam int OCNT_W = 5;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(5);

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CONTAINS = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_DUP    = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_ABSENT = 3'd4,
    ST_RANGE  = 3'd5
  } status_e;

  typedef struct packed {
    logic load;   // capture request
    logic cmp;    // evaluate cell compares
    logic exec;   // update cells, load result
  } dp_cmd_t;

endpackage

// ===== rtl/bsst_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsst_ctrl
// Request sequencer: accept, compare, execute; owns the result valid flag.
// ----------------------------------------------------------------------------
module bsst_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bsst_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        if (out_free) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec  = 1'b1;
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_to_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_CMP)
    else $error("accepted request did not enter compare");

  a_exec_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |-> !out_valid_q)
    else $error("result loaded over an untaken result");

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> out_valid_q && state_q == S_IDLE)
    else $error("execute did not present a result");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !in_ready_o)
    else $error("request accepted while busy");

endmodule

// ===== rtl/bsst_datapath.sv =====
// ----------------------------------------------------------------------------
// bsst_datapath
// Sorted cell array with per-cell compare, shift-insert, shift-remove,
// capacity register and result register.
// ----------------------------------------------------------------------------
module bsst_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  bsst_pkg::dp_cmd_t              cmd_i,
  input  logic                           cfg_we_i,
  input  logic [bsst_pkg::CAP_W-1:0]     cfg_data_i,
  input  logic [bsst_pkg::OP_W-1:0]      op_i,
  input  logic [bsst_pkg::VAL_W-1:0]     value_i,
  input  logic [bsst_pkg::POS_W-1:0]     position_i,
  output logic [bsst_pkg::ST_W-1:0]      status_o,
  output logic                           found_o,
  output logic [bsst_pkg::VAL_W-1:0]     element_o,
  output logic [bsst_pkg::OCNT_W-1:0]    count_o
);

  localparam int D = bsst_pkg::DEPTH;

  logic [bsst_pkg::VAL_W-1:0] elem_q [D];
  logic [bsst_pkg::VAL_W-1:0] elem_d [D];
  logic [bsst_pkg::CNT_W-1:0] count_q, count_d;
  logic [bsst_pkg::CAP_W-1:0] cap_q;

  bsst_pkg::op_e              op_q;
  logic [bsst_pkg::VAL_W-1:0] val_q;
  logic [bsst_pkg::POS_W-1:0] pos_q;

  logic [D-1:0] eq_c, gt_c, tail_c, rm_c;
  logic [D-1:0] tail_q, rm_q;
  logic         hit_q;

  logic [bsst_pkg::ST_W-1:0]  st_d;
  logic                       found_d;
  logic [bsst_pkg::VAL_W-1:0] rd_d;
  logic                       full;
  logic                       do_ins, do_rm;
  logic                       pos_ok;
  logic [bsst_pkg::IDX_W-1:0] rd_idx;

  // compare stage
  always_comb begin
    for (int i = 0; i < D; i++) begin
      eq_c[i]   = (bsst_pkg::CNT_W'(i) < count_q) && (elem_q[i] == val_q);
      gt_c[i]   = (bsst_pkg::CNT_W'(i) < count_q) &&
                  ($signed(val_q) < $signed(elem_q[i]));
      tail_c[i] = gt_c[i] || (bsst_pkg::CNT_W'(i) >= count_q);
    end
    for (int i = 0; i < D; i++) begin
      rm_c[i] = 1'b0;
      for (int j = 0; j < D; j++) begin
        if (j <= i) rm_c[i] = rm_c[i] | eq_c[j];
      end
    end
  end

  // execute stage
  assign full   = ({1'b0, count_q} >= {1'b0, bsst_pkg::CNT_W'(D)}) ||
                  (bsst_pkg::CMP_W'(count_q) >= bsst_pkg::CMP_W'(cap_q));
  assign do_ins = (op_q == bsst_pkg::OP_INSERT) && !full && !hit_q;
  assign do_rm  = (op_q == bsst_pkg::OP_REMOVE) && hit_q;
  assign pos_ok = (pos_q != '0) &&
                  (bsst_pkg::CMP_W'(pos_q) <= bsst_pkg::CMP_W'(count_q));
  assign rd_idx = bsst_pkg::IDX_W'(pos_q - bsst_pkg::POS_W'(1));

  always_comb begin
    st_d    = bsst_pkg::ST_OK;
    found_d = 1'b0;
    rd_d    = '0;
    count_d = count_q;
    unique case (op_q)
      bsst_pkg::OP_INSERT: begin
        if (full)       st_d = bsst_pkg::ST_FULL;
        else if (hit_q) st_d = bsst_pkg::ST_DUP;
        else            count_d = count_q + bsst_pkg::CNT_W'(1);
      end
      bsst_pkg::OP_REMOVE: begin
        if (hit_q)               count_d = count_q - bsst_pkg::CNT_W'(1);
        else if (count_q == '0)  st_d = bsst_pkg::ST_EMPTY;
        else                     st_d = bsst_pkg::ST_ABSENT;
      end
      bsst_pkg::OP_CONTAINS: begin
        found_d = hit_q;
      end
      bsst_pkg::OP_READ: begin
        if (pos_ok) rd_d = elem_q[rd_idx];
        else        st_d = bsst_pkg::ST_RANGE;
      end
      default: begin
        st_d = bsst_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < D; i++) begin
      elem_d[i] = elem_q[i];
      if (do_ins && tail_q[i]) begin
        if (i == 0) begin
          elem_d[i] = val_q;
        end else if (tail_q[i-1]) begin
          elem_d[i] = elem_q[i-1];
        end else begin
          elem_d[i] = val_q;
        end
      end else if (do_rm && rm_q[i] && (i < D - 1)) begin
        elem_d[i] = elem_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= bsst_pkg::CAP_RESET;
    end else begin
      if (cfg_we_i) cap_q <= cfg_data_i;
      if (cmd_i.exec) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= bsst_pkg::op_e'(op_i);
      val_q <= value_i;
      pos_q <= position_i;
    end
    if (cmd_i.cmp) begin
      tail_q <= tail_c;
      rm_q   <= rm_c;
      hit_q  <= |eq_c;
    end
    if (cmd_i.exec) begin
      for (int i = 0; i < D; i++) elem_q[i] <= elem_d[i];
      status_o  <= st_d;
      found_o   <= found_d;
      element_o <= rd_d;
      count_o   <= bsst_pkg::OCNT_W'(count_d);
    end
  end

endmodule

// ===== rtl/bounded_sorted_set_table.sv =====
// ----------------------------------------------------------------------------
// bounded_sorted_set_table
// Sorted set of distinct signed 32-bit values with insert, remove, contains
// and read-by-rank requests, bounded by a writable capacity.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per transaction; m_axis returns exactly one
//   result per request, in order. cfg carries the capacity register and is
//   always ready; write it only while no request is in flight.
//   The accepting edge captures the request; the compare of every cell
//   against the value is then registered, and the execute step shifts the
//   cell array and loads the result register. A new request is accepted at
//   the edge after the result is loaded.
//   If the receiver stalls, one result waits in the output register and the
//   next request is still accepted and compared; it waits in compare until
//   the output register is taken.
//   Reset empties the set (count 0) and sets capacity to 5. The effective
//   limit is the smaller of capacity and the table depth of 16 cells.
// ----------------------------------------------------------------------------
module bounded_sorted_set_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // operation[1:0], value[33:2], position[38:34]
  input  logic [bsst_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // status[2:0], found[3], element[35:4], count[40:36]
  output logic [bsst_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [bsst_pkg::CAP_W-1:0]          cfg_data_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o
);

  bsst_pkg::dp_cmd_t             cmd;
  logic [bsst_pkg::ST_W-1:0]     status;
  logic                          found;
  logic [bsst_pkg::VAL_W-1:0]    element;
  logic [bsst_pkg::OCNT_W-1:0]   count;

  assign cfg_ready_o = 1'b1;

  bsst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  bsst_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .op_i       (s_axis_tdata[1:0]),
    .value_i    (s_axis_tdata[33:2]),
    .position_i (s_axis_tdata[38:34]),
    .status_o   (status),
    .found_o    (found),
    .element_o  (element),
    .count_o    (count)
  );

  assign m_axis_tdata = {7'd0, count, element, found, status};

endmodule
